// ===== hdl/message_interconnect_scheduler_unit_macros.svh =====
// Assertion macros for the message interconnect scheduler
`ifndef MESSAGE_INTERCONNECT_SCHEDULER_UNIT_MACROS_SVH
`define MESSAGE_INTERCONNECT_SCHEDULER_UNIT_MACROS_SVH

// Check that an implication holds on every edge outside reset
`define MIS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define MIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mis_pkg.sv =====
package mis_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned NumPeDef      = 8;
  localparam int unsigned MemWordsDef   = 256;
  localparam logic [31:0] WriteWord     = 32'hDEADBEEF;

  localparam logic OP_ENQ  = 1'b0;
  localparam logic OP_SERV = 1'b1;

  localparam logic [1:0] MT_WRITE = 2'd0;
  localparam logic [1:0] MT_READ  = 2'd1;
  localparam logic [1:0] MT_BCAST = 2'd2;
  localparam logic [1:0] MT_ACK   = 2'd3;

  localparam logic CFG_SCHED_MODE = 1'b0;
  localparam logic CFG_PE_MASK    = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [1:0] msg_type;
    logic [2:0] src_pe;
    logic [7:0] mem_addr;
    logic [3:0] qos_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  resp_type;
    logic [2:0]  dest_pe;
    logic [2:0]  origin_pe;
    logic [7:0]  resp_addr;
    logic [3:0]  resp_qos;
    logic [31:0] read_data;
    logic        status_ok;
    logic        last;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic [1:0] msg_type;
    logic [2:0] src_pe;
    logic [7:0] mem_addr;
    logic [3:0] qos_level;
  } qent_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_SEL, ST_SHIFT, ST_EXEC, ST_MEMRD, ST_RESP,
    ST_FAN, ST_OUT
  } state_t;

endpackage

// ===== hdl/message_interconnect_scheduler_unit.sv =====
// Message interconnect scheduler. Enqueue beats are taken without leaving the
// idle state. A service beat runs through a sequencer: in QoS mode one compare
// unit scans the queue one entry per cycle, then a select step fetches the chosen
// entry, then the queue closes the gap one entry per cycle through the same single
// read port, then an execute step, a word memory read step for reads, and a step
// that forms the response. A broadcast instead steps through PE ids one per
// cycle while the output is not stalled, up to its last target. The input
// stalls meanwhile and until the last result beat is taken. After reset a
// clearing pass zeroes the word memory, during which no beat is taken. Results
// leave through an output register.
`include "message_interconnect_scheduler_unit_macros.svh"

module message_interconnect_scheduler_unit #(
  parameter int unsigned QUEUE_DEPTH = mis_pkg::QueueDepthDef,
  parameter int unsigned NUM_PE      = mis_pkg::NumPeDef,
  parameter int unsigned MEM_WORDS   = mis_pkg::MemWordsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mis_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mis_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata
);

  localparam int unsigned QW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned CLW = $clog2(MEM_WORDS + 1);

  // Stores
  mis_pkg::qent_t queue_mem [QUEUE_DEPTH];
  logic [31:0]    word_mem  [MEM_WORDS];

  mis_pkg::state_t state_r, state_nxt;
  logic            sched_mode_r;
  logic [7:0]      pe_mask_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [QW-1:0]   sel_r, sel_nxt;
  logic [3:0]      best_qos_r, best_qos_nxt;
  mis_pkg::qent_t  rd_r;
  mis_pkg::qent_t  cur_r, cur_nxt;
  logic [31:0]     mrd_r;
  logic            inv_waiting_r, inv_waiting_nxt;
  logic [3:0]      inv_expected_r, inv_expected_nxt;
  logic [3:0]      inv_received_r, inv_received_nxt;
  logic [2:0]      inv_origin_r, inv_origin_nxt;
  logic            overflow_r;
  logic [CLW-1:0]  clr_r;
  logic [2:0]      pe_r, pe_nxt;
  logic [7:0]      pend_r, pend_nxt;
  logic            out_valid_r;
  mis_pkg::out_item_t out_r, res;
  logic            res_v;

  logic            acc_in, is_enq, is_serv, q_full;
  logic [QW-1:0]   q_raddr;
  logic            q_we;
  logic [QW-1:0]   q_waddr;
  mis_pkg::qent_t  q_wdata;
  logic [7:0]      reg_mask;
  logic [3:0]      reg_cnt;
  logic [7:0]      fan_left;
  logic            addr_ok;

  assign in_stall  = (state_r != mis_pkg::ST_IDLE);
  assign acc_in    = in_valid && !in_stall;
  assign is_enq    = acc_in && (in_data.opcode == mis_pkg::OP_ENQ);
  assign is_serv   = acc_in && (in_data.opcode == mis_pkg::OP_SERV) && (count_r != '0);
  assign q_full    = (count_r >= CW'(QUEUE_DEPTH));
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign addr_ok   = (32'(cur_r.mem_addr) < MEM_WORDS);

  // Registered PEs below NUM_PE
  always_comb begin
    reg_cnt = '0;
    for (int i = 0; i < 8; i++) begin
      reg_mask[i] = (i < NUM_PE) && pe_mask_r[i];
      reg_cnt     = reg_cnt + 4'(reg_mask[i]);
    end
  end

  // Pending targets without the current id
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      fan_left[i] = pend_r[i] && (3'(i) != pe_r);
    end
  end

  // Queue read address
  always_comb begin
    unique case (state_r)
      mis_pkg::ST_IDLE:  q_raddr = '0;
      mis_pkg::ST_SEL:   q_raddr = sel_r;
      mis_pkg::ST_SHIFT: q_raddr = QW'(idx_r + CW'(1));
      default:           q_raddr = idx_r[QW-1:0];
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mis_pkg::ST_CLEAR: if (clr_r == CLW'(MEM_WORDS - 1)) state_nxt = mis_pkg::ST_IDLE;
      mis_pkg::ST_IDLE:  if (is_serv) state_nxt = sched_mode_r ? mis_pkg::ST_SCAN
                                                               : mis_pkg::ST_SEL;
      mis_pkg::ST_SCAN:  if (idx_r == count_r + CW'(1)) state_nxt = mis_pkg::ST_SEL;
      mis_pkg::ST_SEL:   state_nxt = mis_pkg::ST_SHIFT;
      mis_pkg::ST_SHIFT: if (idx_r >= count_r) state_nxt = mis_pkg::ST_EXEC;
      mis_pkg::ST_EXEC: begin
        priority case (cur_r.msg_type)
          mis_pkg::MT_READ:  state_nxt = mis_pkg::ST_MEMRD;
          mis_pkg::MT_BCAST: state_nxt = mis_pkg::ST_FAN;
          default:           state_nxt = mis_pkg::ST_RESP;
        endcase
      end
      mis_pkg::ST_MEMRD: state_nxt = mis_pkg::ST_RESP;
      mis_pkg::ST_RESP:  state_nxt = res_v ? mis_pkg::ST_OUT : mis_pkg::ST_IDLE;
      mis_pkg::ST_FAN:   if (pend_r == '0) state_nxt = mis_pkg::ST_IDLE;
                         else if (!out_valid_r || !out_stall) begin
                           if (fan_left == '0) state_nxt = mis_pkg::ST_OUT;
                         end
      mis_pkg::ST_OUT:   if (!out_valid_r || !out_stall) state_nxt = mis_pkg::ST_IDLE;
      default:           state_nxt = mis_pkg::ST_IDLE;
    endcase
  end

  // Datapath outputs of the sequencer
  always_comb begin
    idx_nxt          = idx_r;
    sel_nxt          = sel_r;
    best_qos_nxt     = best_qos_r;
    cur_nxt          = cur_r;
    inv_waiting_nxt  = inv_waiting_r;
    inv_expected_nxt = inv_expected_r;
    inv_received_nxt = inv_received_r;
    inv_origin_nxt   = inv_origin_r;
    pe_nxt           = pe_r;
    pend_nxt         = pend_r;
    q_we             = 1'b0;
    q_waddr          = count_r[QW-1:0];
    q_wdata          = '{in_data.msg_type, in_data.src_pe, in_data.mem_addr,
                         in_data.qos_level};
    res_v            = 1'b0;
    res              = '0;
    res.overflow     = overflow_r;
    unique case (state_r)
      mis_pkg::ST_IDLE: begin
        q_we         = is_enq && !q_full;
        idx_nxt      = CW'(1);
        sel_nxt      = '0;
        best_qos_nxt = '0;
      end
      mis_pkg::ST_SCAN: begin
        // Compare the entry read last cycle; first entry seeds the best
        if ((idx_r == CW'(1)) || (rd_r.qos_level > best_qos_r)) begin
          best_qos_nxt = rd_r.qos_level;
          sel_nxt      = QW'(idx_r - CW'(1));
        end
        idx_nxt = idx_r + CW'(1);
      end
      mis_pkg::ST_SEL: idx_nxt = CW'(sel_r);
      mis_pkg::ST_SHIFT: begin
        if (idx_r == CW'(sel_r)) cur_nxt = rd_r;
        if (idx_r > CW'(sel_r)) begin
          q_we    = 1'b1;
          q_waddr = QW'(idx_r - CW'(1));
          q_wdata = rd_r;
        end
        idx_nxt = idx_r + CW'(1);
      end
      mis_pkg::ST_EXEC: begin
        if (cur_r.msg_type == mis_pkg::MT_BCAST) begin
          inv_waiting_nxt  = 1'b1;
          inv_expected_nxt = reg_cnt;
          inv_received_nxt = '0;
          inv_origin_nxt   = cur_r.src_pe;
          pend_nxt         = reg_mask & ~(8'b1 << cur_r.src_pe);
          pe_nxt           = '0;
        end else if (cur_r.msg_type == mis_pkg::MT_ACK) begin
          inv_received_nxt = (inv_received_r == 4'd15) ? 4'd15 : inv_received_r + 4'd1;
        end
      end
      mis_pkg::ST_RESP: begin
        res.resp_qos = cur_r.qos_level;
        res.last     = 1'b1;
        res.dest_pe  = cur_r.src_pe;
        priority case (cur_r.msg_type)
          mis_pkg::MT_WRITE: begin
            res_v = 1'b1;
            res.resp_type = mis_pkg::MT_WRITE;
            res.status_ok = 1'b1;
          end
          mis_pkg::MT_READ: begin
            res_v = 1'b1;
            res.resp_type = mis_pkg::MT_READ;
            res.resp_addr = cur_r.mem_addr;
            res.read_data = addr_ok ? mrd_r : '0;
          end
          default: begin
            if (inv_waiting_r && (5'(inv_received_r) + 5'd1 >= 5'(inv_expected_r))) begin
              res_v = 1'b1;
              res.resp_type = mis_pkg::MT_ACK;
              res.dest_pe   = inv_origin_r;
              inv_waiting_nxt = 1'b0;
            end
          end
        endcase
      end
      mis_pkg::ST_FAN: begin
        // Step through PE ids, one result per registered target
        if ((pend_r != '0) && (!out_valid_r || !out_stall)) begin
          if (pend_r[pe_r]) begin
            res_v = 1'b1;
            res.resp_type = mis_pkg::MT_BCAST;
            res.dest_pe   = pe_r;
            res.origin_pe = inv_origin_r;
            res.resp_qos  = cur_r.qos_level;
            res.last      = (fan_left == '0);
            pend_nxt      = fan_left;
          end
          pe_nxt = pe_r + 3'd1;
        end
      end
      default: ;
    endcase
  end

  // Queue memory, single read port
  always_ff @(posedge clk) begin
    if (q_we) queue_mem[q_waddr] <= q_wdata;
    rd_r <= queue_mem[q_raddr];
  end

  // Word memory: clear pass, write on write beats, registered read
  always_ff @(posedge clk) begin
    if (state_r == mis_pkg::ST_CLEAR) begin
      word_mem[clr_r[MW-1:0]] <= '0;
    end else if ((state_r == mis_pkg::ST_EXEC) && (cur_r.msg_type == mis_pkg::MT_WRITE)
                 && addr_ok) begin
      word_mem[MW'(cur_r.mem_addr)] <= mis_pkg::WriteWord;
    end
    mrd_r <= word_mem[MW'(cur_r.mem_addr)];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    sel_r      <= sel_nxt;
    best_qos_r <= best_qos_nxt;
    cur_r      <= cur_nxt;
    pe_r       <= pe_nxt;
  end

  // Output register; hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_v) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_v) out_r <= res;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= mis_pkg::ST_CLEAR;
      clr_r          <= '0;
      count_r        <= '0;
      overflow_r     <= 1'b0;
      inv_waiting_r  <= 1'b0;
      inv_expected_r <= '0;
      inv_received_r <= '0;
      inv_origin_r   <= '0;
      pend_r         <= '0;
      sched_mode_r   <= 1'b0;
      pe_mask_r      <= 8'hFF;
    end else begin
      state_r        <= state_nxt;
      clr_r          <= clr_r + CLW'(1);
      inv_waiting_r  <= inv_waiting_nxt;
      inv_expected_r <= inv_expected_nxt;
      inv_received_r <= inv_received_nxt;
      inv_origin_r   <= inv_origin_nxt;
      pend_r         <= pend_nxt;
      if (is_enq) begin
        if (q_full) overflow_r <= 1'b1;
        else        count_r    <= count_r + CW'(1);
      end else if (is_serv) begin
        count_r <= count_r - CW'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          mis_pkg::CFG_SCHED_MODE: sched_mode_r <= cfg_wdata[0];
          mis_pkg::CFG_PE_MASK:    pe_mask_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Checks
  `MIS_ASSERT(a_cnt_bound, 1'b1, count_r <= CW'(QUEUE_DEPTH), "queue count beyond depth")
  `MIS_ASSERT(a_no_take_busy, state_r != mis_pkg::ST_IDLE, !acc_in, "beat taken while busy")
  `MIS_ASSERT_NEXT(a_ovf_sticky, overflow_r, overflow_r, "overflow flag cleared")
  `MIS_ASSERT(a_fan_bcast, res_v && state_r == mis_pkg::ST_FAN,
              res.resp_type == mis_pkg::MT_BCAST, "fan-out result of wrong type")

endmodule

// ===== sim/message_interconnect_scheduler_unit_tb.sv =====
module message_interconnect_scheduler_unit_tb;

  localparam int QDEPTH = mis_pkg::QueueDepthDef;
  localparam int NPE    = mis_pkg::NumPeDef;
  localparam int NWORDS = mis_pkg::MemWordsDef;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  mis_pkg::in_item_t   in_data;
  logic                out_valid;
  logic                out_stall;
  mis_pkg::out_item_t  out_data;
  logic                cfg_we;
  logic                cfg_index;
  logic [7:0]          cfg_wdata;

  message_interconnect_scheduler_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Scheduler state mirror
  mis_pkg::qent_t sq_ent [QDEPTH];
  int          sq_count    = 0;
  logic [31:0] word_mem [NWORDS] = '{default: '0};
  logic        ack_armed   = 1'b0;
  int          ack_needed  = 0;
  int          ack_seen    = 0;
  logic [2:0]  ack_origin  = '0;
  logic        drop_sticky = 1'b0;
  logic        mode_qos    = 1'b0;
  logic [7:0]  pe_reg      = 8'hFF;

  mis_pkg::in_item_t   pending_beats [$];
  mis_pkg::out_item_t  expected_resps [$];
  int          send_idle_pct = 19;
  int          recv_idle_pct = 85;
  bit          hold_send     = 1'b0;
  bit          failed        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Work out the responses one accepted beat causes
  task automatic schedule_beat(input mis_pkg::in_item_t b);
    int                  sel;
    int                  cnt;
    mis_pkg::qent_t      m;
    mis_pkg::out_item_t  r;
    mis_pkg::out_item_t  fan [$];
    if (b.opcode == mis_pkg::OP_ENQ) begin
      if (sq_count >= QDEPTH) begin
        drop_sticky = 1'b1;
      end else begin
        sq_ent[sq_count] = '{b.msg_type, b.src_pe, b.mem_addr, b.qos_level};
        sq_count++;
      end
      return;
    end
    if (sq_count == 0) return;
    sel = 0;
    if (mode_qos) begin
      for (int i = 1; i < sq_count; i++)
        if (sq_ent[i].qos_level > sq_ent[sel].qos_level) sel = i;
    end
    m = sq_ent[sel];
    for (int i = sel; i + 1 < sq_count; i++) sq_ent[i] = sq_ent[i + 1];
    sq_count--;
    r = '0;
    r.resp_qos = m.qos_level;
    r.overflow = drop_sticky;
    case (m.msg_type)
      mis_pkg::MT_WRITE: begin
        word_mem[m.mem_addr] = mis_pkg::WriteWord;
        r.resp_type = mis_pkg::MT_WRITE;
        r.dest_pe   = m.src_pe;
        r.status_ok = 1'b1;
        r.last      = 1'b1;
        expected_resps = {expected_resps, r};
      end
      mis_pkg::MT_READ: begin
        r.resp_type = mis_pkg::MT_READ;
        r.dest_pe   = m.src_pe;
        r.resp_addr = m.mem_addr;
        r.read_data = word_mem[m.mem_addr];
        r.last      = 1'b1;
        expected_resps = {expected_resps, r};
      end
      mis_pkg::MT_BCAST: begin
        cnt = 0;
        for (int i = 0; i < NPE; i++) if (pe_reg[i]) cnt++;
        ack_armed  = 1'b1;
        ack_needed = cnt;
        ack_seen   = 0;
        ack_origin = m.src_pe;
        for (int i = 0; i < NPE; i++) begin
          if (pe_reg[i] && i != m.src_pe) begin
            r.resp_type = mis_pkg::MT_BCAST;
            r.dest_pe   = i[2:0];
            r.origin_pe = m.src_pe;
            fan = {fan, r};
          end
        end
        if (fan.size() > 0) fan[fan.size() - 1].last = 1'b1;
        expected_resps = {expected_resps, fan};
      end
      default: begin
        if (ack_seen < 15) ack_seen++;
        if (ack_armed && ack_seen + 1 >= ack_needed) begin
          r.resp_type = mis_pkg::MT_ACK;
          r.dest_pe   = ack_origin;
          r.last      = 1'b1;
          expected_resps = {expected_resps, r};
          ack_armed = 1'b0;
        end
      end
    endcase
  endtask

  // Driver: present queued beats, idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) schedule_beat(in_data);
      if (pending_beats.size() > 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_beats.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each response beat against the oldest prediction
  always @(posedge clk) begin
    mis_pkg::out_item_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_resps.size() == 0) begin
          $error("unexpected response beat %p", out_data);
          failed = 1'b1;
        end else begin
          e = expected_resps.pop_front();
          if (out_data.resp_type !== e.resp_type) begin
            $error("resp_type exp %0d got %0d", e.resp_type, out_data.resp_type);
            failed = 1'b1;
          end
          if (out_data.dest_pe !== e.dest_pe) begin
            $error("dest_pe exp %0d got %0d", e.dest_pe, out_data.dest_pe);
            failed = 1'b1;
          end
          if (out_data.origin_pe !== e.origin_pe) begin
            $error("origin_pe exp %0d got %0d", e.origin_pe, out_data.origin_pe);
            failed = 1'b1;
          end
          if (out_data.resp_addr !== e.resp_addr) begin
            $error("resp_addr exp %0d got %0d", e.resp_addr, out_data.resp_addr);
            failed = 1'b1;
          end
          if (out_data.resp_qos !== e.resp_qos) begin
            $error("resp_qos exp %0d got %0d", e.resp_qos, out_data.resp_qos);
            failed = 1'b1;
          end
          if (out_data.read_data !== e.read_data) begin
            $error("read_data exp %h got %h", e.read_data, out_data.read_data);
            failed = 1'b1;
          end
          if (out_data.status_ok !== e.status_ok) begin
            $error("status_ok exp %0d got %0d", e.status_ok, out_data.status_ok);
            failed = 1'b1;
          end
          if (out_data.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_data.last);
            failed = 1'b1;
          end
          if (out_data.overflow !== e.overflow) begin
            $error("overflow exp %0d got %0d", e.overflow, out_data.overflow);
            failed = 1'b1;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic mis_pkg::in_item_t mk_beat(logic op, logic [1:0] t, logic [2:0] s,
                                                logic [7:0] a, logic [3:0] q);
    mis_pkg::in_item_t b;
    b = '{op, t, s, a, q};
    return b;
  endfunction

  function automatic mis_pkg::in_item_t rand_enq();
    int t;
    t = $urandom_range(9);
    // favour writes and reads; broadcasts and acks less often
    return mk_beat(mis_pkg::OP_ENQ, (t < 3) ? mis_pkg::MT_WRITE :
                   (t < 6) ? mis_pkg::MT_READ :
                   (t < 8) ? mis_pkg::MT_BCAST : mis_pkg::MT_ACK,
                   3'($urandom_range(7)), 8'($urandom_range(255)),
                   4'($urandom_range(15)));
  endfunction

  // Wait until the block is drained and idle
  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mis_pkg::CFG_SCHED_MODE) mode_qos = val[0];
    else pe_reg = val;
  endtask

  task automatic random_phase(input int n);
    int burst;
    for (int i = 0; i < n; i += burst) begin
      burst = $urandom_range(1, 6);
      for (int k = 0; k < burst; k++) pending_beats = {pending_beats, rand_enq()};
      for (int k = 0; k < burst; k++)
        pending_beats = {pending_beats,
                         mk_beat(mis_pkg::OP_SERV, 2'($urandom_range(3)),
                                 3'($urandom_range(7)), 8'($urandom_range(255)),
                                 4'($urandom_range(15)))};
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = mis_pkg::CFG_SCHED_MODE;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: read of zero memory, write then read back, extremes, empty service
    pending_beats = {pending_beats,
                     mk_beat(mis_pkg::OP_SERV, mis_pkg::MT_READ, 3'd7, 8'hFF, 4'hF)};
    pending_beats = {pending_beats,
                     mk_beat(mis_pkg::OP_ENQ, mis_pkg::MT_READ, 3'd0, 8'd0, 4'd0)};
    pending_beats = {pending_beats,
                     mk_beat(mis_pkg::OP_ENQ, mis_pkg::MT_WRITE, 3'd7, 8'hFF, 4'hF)};
    pending_beats = {pending_beats,
                     mk_beat(mis_pkg::OP_ENQ, mis_pkg::MT_READ, 3'd5, 8'hFF, 4'hA)};
    pending_beats = {pending_beats,
                     mk_beat(mis_pkg::OP_ENQ, mis_pkg::MT_BCAST, 3'd2, 8'h55, 4'h3)};
    pending_beats = {pending_beats,
                     mk_beat(mis_pkg::OP_ENQ, mis_pkg::MT_ACK, 3'd1, 8'hAA, 4'h5)};
    pending_beats = {pending_beats,
                     mk_beat(mis_pkg::OP_ENQ, mis_pkg::MT_ACK, 3'd6, 8'h0F, 4'h9)};
    repeat (6)
      pending_beats = {pending_beats,
                       mk_beat(mis_pkg::OP_SERV, mis_pkg::MT_ACK, 3'd7, 8'hFF, 4'hF)};
    // Fill past depth to drop and set overflow, then drain
    repeat (18)
      pending_beats = {pending_beats,
                       mk_beat(mis_pkg::OP_ENQ, mis_pkg::MT_ACK, 3'd3, 8'h11, 4'd1)};
    repeat (16)
      pending_beats = {pending_beats,
                       mk_beat(mis_pkg::OP_SERV, mis_pkg::MT_WRITE, 3'd0, 8'd0, 4'd0)};
    drain();

    // QoS mode, only PE 4 registered: broadcast from 4 yields nothing
    write_reg(mis_pkg::CFG_SCHED_MODE, 8'd1);
    write_reg(mis_pkg::CFG_PE_MASK, 8'h10);
    pending_beats = {pending_beats,
                     mk_beat(mis_pkg::OP_ENQ, mis_pkg::MT_BCAST, 3'd4, 8'd1, 4'd2)};
    pending_beats = {pending_beats,
                     mk_beat(mis_pkg::OP_ENQ, mis_pkg::MT_READ, 3'd1, 8'd9, 4'd7)};
    pending_beats = {pending_beats,
                     mk_beat(mis_pkg::OP_ENQ, mis_pkg::MT_WRITE, 3'd2, 8'd9, 4'd7)};
    pending_beats = {pending_beats,
                     mk_beat(mis_pkg::OP_ENQ, mis_pkg::MT_ACK, 3'd2, 8'd9, 4'd1)};
    repeat (4)
      pending_beats = {pending_beats,
                       mk_beat(mis_pkg::OP_SERV, mis_pkg::MT_READ, 3'd0, 8'd0, 4'd0)};
    random_phase(60);
    drain();

    // Pause the sender until every response is back
    hold_send = 1'b1;
    drain();
    hold_send = 1'b0;

    send_idle_pct = 85;
    recv_idle_pct = 19;
    write_reg(mis_pkg::CFG_PE_MASK, 8'h00);
    random_phase(30);
    drain();
    write_reg(mis_pkg::CFG_SCHED_MODE, 8'd0);
    write_reg(mis_pkg::CFG_PE_MASK, 8'hFF);
    random_phase(30);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(mis_pkg::CFG_SCHED_MODE, 8'd1);
    write_reg(mis_pkg::CFG_PE_MASK, 8'($urandom_range(255)));
    random_phase(60);
    drain();
    repeat (100) @(posedge clk);

    if (!failed && expected_resps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Give up after a generous time
  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule
